[src/leaky_integrator_regulator_core_assert.svh]
// Assertion macros used by the leaky integrator regulator core.
`ifndef LEAKY_INTEGRATOR_REGULATOR_CORE_ASSERT_SVH
`define LEAKY_INTEGRATOR_REGULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lir_pkg.sv]
// Types, codes and helper functions for the leaky integrator regulator.
package lir_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    // command codes
    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_INTEG  = 2'd0;
    localparam logic [1:0] STAT_BYPASS = 2'd1;
    localparam logic [1:0] STAT_IDLE   = 2'd2;
    localparam logic [1:0] STAT_BADCFG = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OMAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OMIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd7;

    // register reset values
    localparam logic signed [31:0] RST_ONE  = 32'sd65536;
    localparam logic signed [31:0] RST_DT   = 32'sd655;
    localparam logic signed [31:0] RST_OMAX = 32'sd655360;
    localparam logic signed [31:0] RST_OMIN = -32'sd655360;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [31:0] gain;
        logic signed [31:0] ri;
        logic signed [31:0] rf;
        logic signed [31:0] cf;
        logic signed [31:0] dt;
        logic signed [31:0] omax;
        logic signed [31:0] omin;
        logic               bypass;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic        [30:0] divisor;   // known positive
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] quotient;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI[31:0];
        end else if (x < SAT_LO) begin
            y = SAT_LO[31:0];
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // max is checked first when the bounds cross: values above max get max, the rest get min
    function automatic logic signed [31:0] clamp(input logic signed [31:0] x,
                                                 input logic signed [31:0] hi,
                                                 input logic signed [31:0] lo);
        logic signed [31:0] y;
        if (x > hi) begin
            y = hi;
        end else if (x < lo) begin
            y = lo;
        end else begin
            y = x;
        end
        return y;
    endfunction

endpackage

[src/lir_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
interface lir_cmd_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  command;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;

    modport source (output valid, output command, output setpoint, output measured,
                    input ready);
    modport sink   (input valid, input command, input setpoint, input measured,
                    output ready);
endinterface

interface lir_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic        [1:0]  status;

    modport source (output valid, output drive, output status, input ready);
    modport sink   (input valid, input drive, input status, output ready);
endinterface

[src/lir_cfg.sv]
// Configuration register file with write decode.
module lir_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lir_pkg::DATA_W-1:0]       i_cfg_data,
    output lir_pkg::t_cfg                    o_cfg
);

    lir_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= lir_pkg::RST_ONE;
            r_cfg.ri     <= lir_pkg::RST_ONE;
            r_cfg.rf     <= lir_pkg::RST_ONE;
            r_cfg.cf     <= lir_pkg::RST_ONE;
            r_cfg.dt     <= lir_pkg::RST_DT;
            r_cfg.omax   <= lir_pkg::RST_OMAX;
            r_cfg.omin   <= lir_pkg::RST_OMIN;
            r_cfg.bypass <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lir_pkg::REG_GAIN:   r_cfg.gain   <= $signed(i_cfg_data);
                lir_pkg::REG_RI:     r_cfg.ri     <= $signed(i_cfg_data);
                lir_pkg::REG_RF:     r_cfg.rf     <= $signed(i_cfg_data);
                lir_pkg::REG_CF:     r_cfg.cf     <= $signed(i_cfg_data);
                lir_pkg::REG_DT:     r_cfg.dt     <= $signed(i_cfg_data);
                lir_pkg::REG_OMAX:   r_cfg.omax   <= $signed(i_cfg_data);
                lir_pkg::REG_OMIN:   r_cfg.omin   <= $signed(i_cfg_data);
                lir_pkg::REG_BYPASS: r_cfg.bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/lir_div.sv]
// Iterative signed divider, 64-bit dividend by positive 31-bit divisor, 2 bits a cycle.
module lir_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lir_pkg::t_div_req i_req,
    output lir_pkg::t_div_rsp o_rsp
);

    logic        [63:0] r_mag;    // dividend bits out, quotient bits in
    logic        [30:0] r_rem;
    logic        [30:0] r_dsr;
    logic               r_neg;
    logic        [4:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    logic        [31:0] w_t1;
    logic        [31:0] w_t2;
    logic               w_ge1;
    logic               w_ge2;
    logic        [30:0] w_rem1;
    logic        [30:0] w_rem2;
    logic        [63:0] w_abs;

    always_comb begin
        w_t1   = {r_rem, r_mag[63]};
        w_ge1  = w_t1 >= {1'b0, r_dsr};
        w_rem1 = w_ge1 ? 31'(w_t1 - {1'b0, r_dsr}) : w_t1[30:0];
        w_t2   = {w_rem1, r_mag[62]};
        w_ge2  = w_t2 >= {1'b0, r_dsr};
        w_rem2 = w_ge2 ? 31'(w_t2 - {1'b0, r_dsr}) : w_t2[30:0];
    end

    assign w_abs = i_req.dividend[63] ? 64'(-i_req.dividend) : i_req.dividend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mag  <= w_abs;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
                r_neg  <= i_req.dividend[63];
            end else if (r_busy) begin
                r_mag <= {r_mag[61:0], w_ge1, w_ge2};
                r_rem <= w_rem2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

[src/leaky_integrator_regulator_core.sv]
// Top level of the leaky integrator regulator: sequencer, multiplier and result register.
//
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        command[1:0], setpoint[31:0], measured[31:0]
//  o_res     out  valid/ready        drive[31:0], status[1:0]
//  i_cfg_*   in   write enable only  i_cfg_idx[2:0], i_cfg_data[31:0]
//
// Start, stop, unused codes and execute beats that end in not-running, bypass or
// bad configuration are answered from idle; the result register loads at the accepting edge.
// An integrating execute makes three divider passes (input, leak, delta), each a
// multiply state, a launch state and a wait for the divider's 32 iterations at
// 2 quotient bits per cycle, then goes through a clamp state that writes the result
// once the result register is free.
// Reset is synchronous and active low; it returns the block to ready with v = 0.
// A stalled result holds o_res; the block then accepts a command only when the
// result register frees in the same cycle.
`include "leaky_integrator_regulator_core_assert.svh"

module leaky_integrator_regulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lir_cmd_if.sink                       i_cmd,
    lir_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lir_pkg::DATA_W-1:0]    i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;  // load dividend
    localparam logic [2:0] ST_START = 3'd2;  // launch divider
    localparam logic [2:0] ST_WAIT  = 3'd3;  // divider running
    localparam logic [2:0] ST_OUT   = 3'd4;  // clamp and write result

    // divider passes
    localparam logic [1:0] PH_INPUT = 2'd0;  // gain*(sp-mv) / Ri
    localparam logic [1:0] PH_LEAK  = 2'd1;  // v*1.0 / Rf
    localparam logic [1:0] PH_DELTA = 2'd2;  // cur*dt / Cf

    lir_pkg::t_cfg      w_cfg;
    lir_pkg::t_div_req  w_div_req;
    lir_pkg::t_div_rsp  w_div_rsp;

    logic [2:0]         r_state;
    logic [1:0]         r_phase;
    logic               r_running;
    logic signed [31:0] r_v;        // integrator
    logic signed [32:0] r_a;        // multiplicand: sp-mv, then cur
    logic signed [63:0] r_num;      // dividend for the current pass
    logic signed [31:0] r_in;       // saturated input term
    logic signed [31:0] r_raw;      // saturated v + delta
    logic               r_o_valid;
    logic signed [31:0] r_o_drive;
    logic        [1:0]  r_o_status;
    logic               n_o_valid;
    logic signed [31:0] n_o_drive;
    logic        [1:0]  n_o_status;

    logic               w_out_free;
    logic               w_in_fire;
    logic               w_bad_cfg;
    logic signed [31:0] w_mul_b;
    logic signed [64:0] w_prod;
    logic        [30:0] w_divisor;
    logic signed [31:0] w_qsat;
    logic signed [31:0] w_cur;
    logic signed [31:0] w_sp_clamp;
    logic signed [31:0] w_v_clamp;

    lir_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    lir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // handshakes
    assign w_out_free  = !r_o_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_fire   = i_cmd.valid && i_cmd.ready;

    // non-positive Ri, Rf, Cf or dt
    assign w_bad_cfg = w_cfg.ri[31] || (w_cfg.ri == '0) ||
                       w_cfg.rf[31] || (w_cfg.rf == '0) ||
                       w_cfg.cf[31] || (w_cfg.cf == '0) ||
                       w_cfg.dt[31] || (w_cfg.dt == '0);

    // shared multiplier, result registered into r_num
    assign w_mul_b = (r_phase == PH_INPUT) ? w_cfg.gain : w_cfg.dt;
    assign w_prod  = r_a * w_mul_b;

    always_comb begin
        case (r_phase)
            PH_INPUT: w_divisor = w_cfg.ri[30:0];
            PH_LEAK:  w_divisor = w_cfg.rf[30:0];
            default:  w_divisor = w_cfg.cf[30:0];
        endcase
    end

    assign w_div_req.start    = (r_state == ST_START);
    assign w_div_req.dividend = r_num;
    assign w_div_req.divisor  = w_divisor;

    assign w_qsat     = lir_pkg::sat32(w_div_rsp.quotient);
    assign w_cur      = lir_pkg::sat32({{32{r_in[31]}}, r_in} - {{32{w_qsat[31]}}, w_qsat});
    assign w_sp_clamp = lir_pkg::clamp(i_cmd.setpoint, w_cfg.omax, w_cfg.omin);
    assign w_v_clamp  = lir_pkg::clamp(r_raw, w_cfg.omax, w_cfg.omin);

    // result register: freed by a taken beat, loaded by a short execute or the clamp stage
    always_comb begin
        n_o_valid  = r_o_valid && !o_res.ready;
        n_o_drive  = r_o_drive;
        n_o_status = r_o_status;
        if (w_in_fire && (i_cmd.command == lir_pkg::CMD_EXEC)) begin
            if (!r_running) begin
                n_o_valid  = 1'b1;
                n_o_drive  = '0;
                n_o_status = lir_pkg::STAT_IDLE;
            end else if (w_cfg.bypass) begin
                n_o_valid  = 1'b1;
                n_o_drive  = w_sp_clamp;
                n_o_status = lir_pkg::STAT_BYPASS;
            end else if (w_bad_cfg) begin
                n_o_valid  = 1'b1;
                n_o_drive  = '0;
                n_o_status = lir_pkg::STAT_BADCFG;
            end
        end else if ((r_state == ST_OUT) && w_out_free) begin
            n_o_valid  = 1'b1;
            n_o_drive  = w_v_clamp;
            n_o_status = lir_pkg::STAT_INTEG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_INPUT;
            r_running  <= 1'b0;
            r_v        <= '0;
            r_o_valid  <= 1'b0;
            r_o_drive  <= '0;
            r_o_status <= lir_pkg::STAT_INTEG;
        end else begin
            r_o_valid  <= n_o_valid;
            r_o_drive  <= n_o_drive;
            r_o_status <= n_o_status;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        case (i_cmd.command)
                            lir_pkg::CMD_START: begin
                                if (!r_running) begin
                                    r_v       <= '0;
                                    r_running <= 1'b1;
                                end
                            end
                            lir_pkg::CMD_STOP: begin
                                r_running <= 1'b0;
                            end
                            lir_pkg::CMD_EXEC: begin
                                // short cases are answered by the result register alone
                                if (r_running && !w_cfg.bypass && !w_bad_cfg) begin
                                    r_a     <= {i_cmd.setpoint[31], i_cmd.setpoint} -
                                               {i_cmd.measured[31], i_cmd.measured};
                                    r_phase <= PH_INPUT;
                                    r_state <= ST_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    if (r_phase == PH_LEAK) begin
                        r_num <= {{16{r_v[31]}}, r_v, 16'h0000};
                    end else begin
                        r_num <= w_prod[63:0];
                    end
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_div_rsp.done) begin
                        case (r_phase)
                            PH_INPUT: begin
                                r_in    <= w_qsat;
                                r_phase <= PH_LEAK;
                                r_state <= ST_MUL;
                            end
                            PH_LEAK: begin
                                r_a     <= {w_cur[31], w_cur};
                                r_phase <= PH_DELTA;
                                r_state <= ST_MUL;
                            end
                            default: begin
                                r_raw   <= lir_pkg::sat32({{32{r_v[31]}}, r_v} +
                                                          w_div_rsp.quotient);
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_v     <= w_v_clamp;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid  = r_o_valid;
    assign o_res.drive  = r_o_drive;
    assign o_res.status = r_o_status;

    // divider only answers while the sequencer waits for it
    `LIR_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, w_div_rsp.done,
        r_state == ST_WAIT, "divider done outside wait state")
    // an integrated result carries the new integrator value
    `LIR_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == ST_OUT) && w_out_free,
        r_o_valid && (r_o_status == lir_pkg::STAT_INTEG) && (r_o_drive == r_v),
        "integrated result does not match integrator")
    // start always leaves the block running and back in the idle state
    `LIR_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n,
        w_in_fire && (i_cmd.command == lir_pkg::CMD_START),
        r_running && (r_state == ST_IDLE), "start did not enter running")
    // execute while stopped reports and leaves the integrator alone
    `LIR_ASSERT_NEXT(a_stopped_exec, i_clk, i_rst_n,
        w_in_fire && (i_cmd.command == lir_pkg::CMD_EXEC) && !r_running,
        $stable(r_v) && r_o_valid && (r_o_status == lir_pkg::STAT_IDLE),
        "execute while stopped misbehaved")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for leaky_integrator_regulator_core: directed plan, random phases.
`timescale 1ns / 100ps

module tb_top;

    localparam int      CLK_PERIOD    = 12;
    localparam int      RESET_CYCLES  = 7;
    localparam int      SETTLE_CYCLES = 150;        // room for an integrating execute to finish
    localparam int      PHASES        = 10;
    localparam int      PHASE_EXECS   = 125;        // executes per random phase
    localparam int      WATCHDOG_NS   = 20_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint  WORD_HI       = 64'sd2147483647;
    localparam longint  WORD_LO       = -64'sd2147483648;
    localparam logic [31:0] W_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] drive;
        logic        [1:0]  status;
    } t_drive_rec;

    // one line of the directed plan: a register write or a command beat
    typedef struct packed {
        logic                          is_cfg;
        logic [lir_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                   data;
        logic [1:0]                    cmd;
        logic [31:0]                   sp;
        logic [31:0]                   mv;
        logic                          typed;   // expected result written out by hand
        t_drive_rec                    want;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;
    logic                          cfg_we;
    logic [lir_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [lir_pkg::DATA_W-1:0]    cfg_data;

    lir_cmd_if cmd_if ();
    lir_res_if res_if ();

    leaky_integrator_regulator_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Regulator state as the testbench tracks it
    // ---------------------------------------------------------------
    logic signed [31:0] k_gain = lir_pkg::RST_ONE;
    logic signed [31:0] k_ri   = lir_pkg::RST_ONE;
    logic signed [31:0] k_rf   = lir_pkg::RST_ONE;
    logic signed [31:0] k_cf   = lir_pkg::RST_ONE;
    logic signed [31:0] k_dt   = lir_pkg::RST_DT;
    logic signed [31:0] k_omax = lir_pkg::RST_OMAX;
    logic signed [31:0] k_omin = lir_pkg::RST_OMIN;
    logic               k_bypass = 1'b0;
    logic signed [31:0] integ_v  = '0;
    logic               run_flag = 1'b0;

    t_drive_rec due_drives[$];   // results owed by the block, oldest first
    t_stim_row  stim_plan[$];
    int         fail_cnt   = 0;
    int         burst_left = 0;

    function automatic longint sat_word(input longint x);
        if (x > WORD_HI) return WORD_HI;
        if (x < WORD_LO) return WORD_LO;
        return x;
    endfunction

    // upper bound checked first: with crossed bounds, values above it get it, the rest the lower
    function automatic logic signed [31:0] clamp_out(input longint x);
        if (x > longint'(k_omax)) return k_omax;
        if (x < longint'(k_omin)) return k_omin;
        return x[31:0];
    endfunction

    // Advances the tracked state by one command beat; returns 1 when a result is due.
    function automatic bit step_regulator(input logic [1:0] cmd, input logic signed [31:0] sp,
                                          input logic signed [31:0] mv, output t_drive_rec rec);
        longint err_in;
        longint leak;
        longint cur;
        longint delta;
        longint raw;
        rec = '0;
        if (cmd == lir_pkg::CMD_START) begin
            if (!run_flag) begin
                integ_v  = '0;
                run_flag = 1'b1;
            end
            return 1'b0;
        end
        if (cmd == lir_pkg::CMD_STOP) begin
            run_flag = 1'b0;
            return 1'b0;
        end
        if (cmd != lir_pkg::CMD_EXEC) return 1'b0;

        if (!run_flag) begin
            rec.status = lir_pkg::STAT_IDLE;
        end else if (k_bypass) begin
            // bypass wins over a bad configuration; integrator untouched
            rec.drive  = clamp_out(longint'(sp));
            rec.status = lir_pkg::STAT_BYPASS;
        end else if (k_ri <= 0 || k_rf <= 0 || k_cf <= 0 || k_dt <= 0) begin
            rec.status = lir_pkg::STAT_BADCFG;
        end else begin
            // (sp-mv)*gain stays inside 64 bits; divides truncate toward zero
            err_in = sat_word(((longint'(sp) - longint'(mv)) * longint'(k_gain))
                              / longint'(k_ri));
            leak   = sat_word((longint'(integ_v) * 64'sd65536) / longint'(k_rf));
            cur    = sat_word(err_in - leak);
            delta  = (cur * longint'(k_dt)) / longint'(k_cf);
            raw    = sat_word(longint'(integ_v) + delta);
            integ_v    = clamp_out(raw);
            rec.drive  = integ_v;
            rec.status = lir_pkg::STAT_INTEG;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Plan rows
    // ---------------------------------------------------------------
    function automatic t_stim_row reg_row(input logic [lir_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] data);
        t_stim_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_stim_row beat_row(input logic [1:0] cmd, input logic [31:0] sp,
                                           input logic [31:0] mv);
        t_stim_row r;
        r     = '0;
        r.cmd = cmd;
        r.sp  = sp;
        r.mv  = mv;
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic [31:0] sp, input logic [31:0] drv,
                                            input logic [1:0] st);
        t_stim_row r;
        r             = beat_row(lir_pkg::CMD_EXEC, sp, 32'd0);
        r.typed       = 1'b1;
        r.want.drive  = drv;
        r.want.status = st;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random values
    // ---------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            2: begin
                case ($urandom_range(0, 4))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return 32'd0;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'd1;
                endcase
            end
            default: return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    function automatic logic [31:0] pos_word();
        case ($urandom_range(0, 5))
            0:       return 32'd1;
            1:       return W_MAX;
            2:       return $urandom_range(1, W_MAX);
            default: return $urandom_range(1 << 12, 1 << 20);
        endcase
    endfunction

    function automatic logic [31:0] bad_word();
        if ($urandom_range(0, 1)) return 32'd0;
        return $urandom | W_MIN;
    endfunction

    // ---------------------------------------------------------------
    // Drivers: everything changes just after the falling edge
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [lir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            lir_pkg::REG_GAIN:   k_gain   = data;
            lir_pkg::REG_RI:     k_ri     = data;
            lir_pkg::REG_RF:     k_rf     = data;
            lir_pkg::REG_CF:     k_cf     = data;
            lir_pkg::REG_DT:     k_dt     = data;
            lir_pkg::REG_OMAX:   k_omax   = data;
            lir_pkg::REG_OMIN:   k_omin   = data;
            lir_pkg::REG_BYPASS: k_bypass = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Block idle: nothing owed, then time for a silent execute to finish.
    task automatic settle();
        cmd_if.valid = 1'b0;
        while (due_drives.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Offers one command beat; returns at the falling edge after it was taken,
    // valid still high so a following beat goes out back to back.
    task automatic send_beat(input logic [1:0] cmd, input logic [31:0] sp,
                             input logic [31:0] mv, input logic typed,
                             input t_drive_rec typed_rec);
        int         gap;
        t_drive_rec rec;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                8:       gap = $urandom_range(5, 20);
                default: gap = $urandom_range(1, 4);
            endcase
            if ($urandom_range(0, 39) == 0) begin
                // hold off until the block has handed back everything
                cmd_if.valid = 1'b0;
                while (due_drives.size() != 0) @(negedge clk);
            end
            repeat (gap) begin
                cmd_if.valid    = 1'b0;
                cmd_if.command  = $urandom;
                cmd_if.setpoint = $urandom;
                cmd_if.measured = $urandom;
                @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;

        cmd_if.valid    = 1'b1;
        cmd_if.command  = cmd;
        cmd_if.setpoint = sp;
        cmd_if.measured = mv;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        @(negedge clk);
        if (step_regulator(cmd, sp, mv, rec)) begin
            due_drives.push_back(typed ? typed_rec : rec);
        end
    endtask

    // One register setting per random phase; phase 0 goes back to reset values.
    task automatic set_phase(input int ph);
        logic [31:0] gain, ri, rf, cf, dt, omax, omin;
        int          lim;
        if (ph == 0) begin
            gain = lir_pkg::RST_ONE;
            ri   = lir_pkg::RST_ONE;
            rf   = lir_pkg::RST_ONE;
            cf   = lir_pkg::RST_ONE;
            dt   = lir_pkg::RST_DT;
            omax = lir_pkg::RST_OMAX;
            omin = lir_pkg::RST_OMIN;
        end else begin
            case ($urandom_range(0, 4))
                0:       gain = $urandom;
                1:       gain = W_MAX;
                2:       gain = W_MIN;
                default: gain = 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
            endcase
            ri = pos_word();
            rf = pos_word();
            cf = pos_word();
            dt = pos_word();
            if (ph % 4 == 2) begin
                case ($urandom_range(0, 3))
                    0:       ri = bad_word();
                    1:       rf = bad_word();
                    2:       cf = bad_word();
                    default: dt = bad_word();
                endcase
            end
            case ($urandom_range(0, 4))
                0: begin
                    omax = W_MAX;
                    omin = W_MIN;
                end
                1: begin
                    omax = $urandom_range(1, 1 << 24);
                    omin = 32'(-int'($urandom_range(1, 1 << 24)));
                end
                2: begin
                    // crossed bounds
                    omax = 32'(-int'($urandom_range(0, 1 << 20)));
                    omin = $urandom_range(0, 1 << 20);
                end
                default: begin
                    lim  = $urandom_range(1 << 16, 1 << 22);
                    omax = lim;
                    omin = 32'(-lim);
                end
            endcase
        end
        write_reg(lir_pkg::REG_GAIN, gain);
        write_reg(lir_pkg::REG_RI, ri);
        write_reg(lir_pkg::REG_RF, rf);
        write_reg(lir_pkg::REG_CF, cf);
        write_reg(lir_pkg::REG_DT, dt);
        write_reg(lir_pkg::REG_OMAX, omax);
        write_reg(lir_pkg::REG_OMIN, omin);
        write_reg(lir_pkg::REG_BYPASS, 32'(ph % 5 == 4));
    endtask

    // ---------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------
    initial begin : res_stall_gen
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 9) < 2) begin
                // stretch without back-pressure
                res_if.ready = 1'b1;
                hold         = $urandom_range(20, 150);
            end else begin
                res_if.ready = !res_if.ready;
                hold         = res_if.ready ? $urandom_range(0, 10) : $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk) begin : res_check
        t_drive_rec want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (due_drives.size() == 0) begin
                fail_cnt++;
                $display("%0t: result beat: expected none actual drive %0d status %0d",
                         $time, res_if.drive, res_if.status);
            end else begin
                want = due_drives.pop_front();
                if (res_if.drive !== want.drive) begin
                    fail_cnt++;
                    $display("%0t: drive mismatch: expected %0d actual %0d",
                             $time, want.drive, res_if.drive);
                end
                if (res_if.status !== want.status) begin
                    fail_cnt++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, res_if.status);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin : run_seq
        int          execs;
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] sp;
        logic [31:0] mv;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        cmd_if.valid    = 1'b0;
        cmd_if.command  = lir_pkg::CMD_EXEC;
        cmd_if.setpoint = '0;
        cmd_if.measured = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed plan, reset settings first
        stim_plan.push_back(known_row(W_MAX, 32'd0, lir_pkg::STAT_IDLE)); // execute from ready
        stim_plan.push_back(beat_row(lir_pkg::CMD_STOP, W_MIN, W_MAX));   // stop while ready
        stim_plan.push_back(beat_row(CMD_UNUSED, W_MIN, W_MAX));          // unused code
        stim_plan.push_back(beat_row(lir_pkg::CMD_START, 32'd0, 32'd0));
        stim_plan.push_back(beat_row(lir_pkg::CMD_START, W_MAX, W_MIN));  // start while running
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, W_MAX, W_MIN));
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, W_MIN, W_MAX));
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, 32'd0, 32'd0));   // pure leak
        // bypass against the reset bounds
        stim_plan.push_back(reg_row(lir_pkg::REG_BYPASS, 32'd1));
        stim_plan.push_back(known_row(W_MAX, lir_pkg::RST_OMAX, lir_pkg::STAT_BYPASS));
        stim_plan.push_back(known_row(W_MIN, lir_pkg::RST_OMIN, lir_pkg::STAT_BYPASS));
        stim_plan.push_back(known_row(32'd12345, 32'd12345, lir_pkg::STAT_BYPASS));
        // crossed bounds: max checked first
        stim_plan.push_back(reg_row(lir_pkg::REG_OMAX, -32'sd100000));
        stim_plan.push_back(reg_row(lir_pkg::REG_OMIN, 32'sd100000));
        stim_plan.push_back(known_row(32'sd200000, -32'sd100000, lir_pkg::STAT_BYPASS));
        stim_plan.push_back(known_row(-32'sd200000, 32'sd100000, lir_pkg::STAT_BYPASS));
        stim_plan.push_back(known_row(32'd0, -32'sd100000, lir_pkg::STAT_BYPASS));
        // bypass ahead of a bad Ri, then the bad settings on their own
        stim_plan.push_back(reg_row(lir_pkg::REG_OMAX, W_MAX));
        stim_plan.push_back(reg_row(lir_pkg::REG_OMIN, W_MIN));
        stim_plan.push_back(reg_row(lir_pkg::REG_RI, 32'd0));
        stim_plan.push_back(known_row(32'd5, 32'd5, lir_pkg::STAT_BYPASS));
        stim_plan.push_back(reg_row(lir_pkg::REG_BYPASS, 32'd0));
        stim_plan.push_back(known_row(32'd1, 32'd0, lir_pkg::STAT_BADCFG));
        stim_plan.push_back(reg_row(lir_pkg::REG_RI, lir_pkg::RST_ONE));
        stim_plan.push_back(reg_row(lir_pkg::REG_DT, 32'hFFFF_FFFF));
        stim_plan.push_back(known_row(32'd1, 32'd0, lir_pkg::STAT_BADCFG));
        // extreme gains and scaling drive every saturation point
        stim_plan.push_back(reg_row(lir_pkg::REG_DT, W_MAX));
        stim_plan.push_back(reg_row(lir_pkg::REG_CF, 32'd1));
        stim_plan.push_back(reg_row(lir_pkg::REG_RF, W_MAX));
        stim_plan.push_back(reg_row(lir_pkg::REG_GAIN, W_MAX));
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, W_MAX, W_MIN));
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, W_MIN, W_MAX));
        stim_plan.push_back(reg_row(lir_pkg::REG_GAIN, W_MIN));
        stim_plan.push_back(reg_row(lir_pkg::REG_RF, 32'd1));
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, W_MAX, W_MIN));
        stim_plan.push_back(beat_row(lir_pkg::CMD_EXEC, 32'd1, 32'd0));
        stim_plan.push_back(reg_row(lir_pkg::REG_CF, 32'd0));
        stim_plan.push_back(known_row(32'd1, 32'd0, lir_pkg::STAT_BADCFG));
        stim_plan.push_back(reg_row(lir_pkg::REG_CF, lir_pkg::RST_ONE));
        stim_plan.push_back(reg_row(lir_pkg::REG_RF, 32'd0));
        stim_plan.push_back(known_row(32'd1, 32'd0, lir_pkg::STAT_BADCFG));
        stim_plan.push_back(beat_row(lir_pkg::CMD_STOP, 32'd0, 32'd0));
        stim_plan.push_back(known_row(W_MAX, 32'd0, lir_pkg::STAT_IDLE)); // stopped again

        foreach (stim_plan[i]) begin
            if (stim_plan[i].is_cfg) begin
                settle();
                write_reg(stim_plan[i].idx, stim_plan[i].data);
            end else begin
                send_beat(stim_plan[i].cmd, stim_plan[i].sp, stim_plan[i].mv,
                          stim_plan[i].typed, stim_plan[i].want);
            end
        end

        // random phases: mostly executes while running, some start/stop churn
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            set_phase(ph);
            send_beat(lir_pkg::CMD_START, rand_word(), rand_word(), 1'b0, '0);
            execs = 0;
            while (execs < PHASE_EXECS) begin
                pick = $urandom_range(0, 99);
                if (pick < 84) begin
                    cmd = lir_pkg::CMD_EXEC;
                end else if (pick < 93) begin
                    cmd = lir_pkg::CMD_START;
                end else if (pick < 97) begin
                    cmd = lir_pkg::CMD_STOP;
                end else begin
                    cmd = CMD_UNUSED;
                end
                sp = rand_word();
                mv = $urandom_range(0, 1) ? rand_word()
                                          : sp + 32'($urandom_range(0, 2000)) - 32'd1000;
                send_beat(cmd, sp, mv, 1'b0, '0);
                if (cmd == lir_pkg::CMD_EXEC) execs++;
            end
        end

        settle();
        if (fail_cnt == 0) begin
            $display("leaky_integrator_regulator_core regression: pass");
        end else begin
            $display("leaky_integrator_regulator_core regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("leaky_integrator_regulator_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/lir_pkg.sv
src/lir_if.sv
src/lir_cfg.sv
src/lir_div.sv
src/leaky_integrator_regulator_core.sv
tb/tb_top.sv
